@@ src/ascii_integer_parse_format_unit_macros.svh @@
// ============================================================================
// ascii integer parse/format unit - assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ============================================================================
`ifndef ASCII_INTEGER_PARSE_FORMAT_UNIT_MACROS_SVH
`define ASCII_INTEGER_PARSE_FORMAT_UNIT_MACROS_SVH

// property must hold at every edge out of reset
`define AIPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define AIPF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/aipf_pkg.sv @@
// ============================================================================
// aipf_pkg
// widths, ascii codes, queue entry types and back-end states
// ============================================================================
`default_nettype none

package aipf_pkg;

  localparam int VALUE_BITS = 32;
  localparam int DIGIT_W    = 4;
  // decimal digits of 2^VALUE_BITS - 1
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
  localparam int PTR_W      = $clog2(DEC_DIGITS);
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int FOLD_W     = VALUE_BITS + 5;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_NINE    = 8'h39;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_F = 8'h46;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_F = 8'h66;

  localparam logic [DIGIT_W-1:0] LETTER_OFS = 4'd9;
  localparam logic [DIGIT_W-1:0] DEC_TEN    = 4'd10;
  localparam logic [DIGIT_W-1:0] BCD_FIVE   = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_THREE  = 4'd3;

  typedef struct packed {
    logic               term;
    logic               hex;
    logic [DIGIT_W-1:0] digit;
  } cmd_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_digit;
    logic       overflowed;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } back_state_e;

endpackage

`default_nettype wire

@@ src/aipf_front.sv @@
// ============================================================================
// aipf_front
// classifies input characters and holds them in a two-entry command queue
// ============================================================================
`default_nettype none

module aipf_front
  import aipf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       hex_i,
  input  wire logic [7:0] char_in_i,
  input  wire logic       push_i,
  output logic            full_o,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o,
  input  wire logic       cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       entry;
  logic       wr_en, rd_en;

  always_comb begin
    entry.hex   = hex_i;
    entry.term  = 1'b1;
    entry.digit = char_in_i[DIGIT_W-1:0];
    if (char_in_i inside {[ASCII_ZERO:ASCII_NINE]}) begin
      entry.term = 1'b0;
    end else if (hex_i && (char_in_i inside {[ASCII_UPPER_A:ASCII_UPPER_F],
                                             [ASCII_LOWER_A:ASCII_LOWER_F]})) begin
      entry.term  = 1'b0;
      entry.digit = char_in_i[DIGIT_W-1:0] + LETTER_OFS;
    end
  end

  assign full_o      = cnt_q[1];
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wptr_q <= !wptr_q;
      end
      if (rd_en) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

@@ src/aipf_back.sv @@
// ============================================================================
// aipf_back
// folds digits into the accumulator and prints the value on a terminator
// ============================================================================
`default_nettype none

module aipf_back
  import aipf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      res_push_o,
  output res_t      res_o,
  input  wire logic res_full_i
);

  back_state_e            state_q, state_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [VALUE_BITS-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic                   started_q, started_d;
  logic [FOLD_W-1:0]      fold;
  logic [DIGIT_W-1:0]     cur_digit;
  logic                   at_lsd;

  // acc * radix + digit, one bit of headroom above the x16 case
  always_comb begin
    if (cmd_i.hex) begin
      fold = {1'b0, acc_q, 4'b0000};
    end else begin
      fold = {2'b00, acc_q, 3'b000} + {4'b0000, acc_q, 1'b0};
    end
    fold = fold + {{(FOLD_W-DIGIT_W){1'b0}}, cmd_i.digit};
  end

  // add-3 correction per bcd digit
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= BCD_FIVE) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + BCD_THREE;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign cur_digit = bcd_q[ptr_q*DIGIT_W +: DIGIT_W];
  assign at_lsd    = (ptr_q == '0);

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    started_d  = started_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;

    res_o.last_digit = at_lsd;
    res_o.overflowed = at_lsd && ovf_q;
    if (cur_digit < DEC_TEN) begin
      res_o.char_out = ASCII_ZERO + {4'b0000, cur_digit};
    end else begin
      res_o.char_out = ASCII_UPPER_A + {4'b0000, cur_digit - DEC_TEN};
    end

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.term) begin
            if (|fold[FOLD_W-1:VALUE_BITS]) begin
              acc_d = '1;
              ovf_d = 1'b1;
            end else begin
              acc_d = fold[VALUE_BITS-1:0];
            end
          end else begin
            started_d = 1'b0;
            ptr_d     = PTR_W'(DEC_DIGITS - 1);
            if (cmd_i.hex) begin
              bcd_d   = {{(BCD_W-VALUE_BITS){1'b0}}, acc_q};
              state_d = BK_EMIT;
            end else begin
              bin_d   = acc_q;
              bcd_d   = '0;
              cnt_d   = '0;
              state_d = BK_CONV;
            end
          end
        end
      end
      BK_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
        bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!started_q && (cur_digit == '0) && !at_lsd) begin
          ptr_d = ptr_q - 1'b1;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          started_d  = 1'b1;
          if (at_lsd) begin
            acc_d   = '0;
            ovf_d   = 1'b0;
            state_d = BK_IDLE;
          end else begin
            ptr_d = ptr_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      acc_q     <= '0;
      ovf_q     <= 1'b0;
      ptr_q     <= '0;
      started_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      ovf_q     <= ovf_d;
      ptr_q     <= ptr_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

`default_nettype wire

@@ src/aipf_outq.sv @@
// ============================================================================
// aipf_outq
// two-entry result queue in front of the output ports
// ============================================================================
`default_nettype none

module aipf_outq
  import aipf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t res_i,
  output logic      full_o,
  output logic      empty_o,
  output res_t      res_o,
  input  wire logic pop_i
);

  res_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = mem_q[rptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wptr_q <= !wptr_q;
      end
      if (rd_en) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ src/ascii_integer_parse_format_unit.sv @@
// ============================================================================
// ascii_integer_parse_format_unit
// parses an ascii decimal or hex number and prints it back as ascii digits
// ============================================================================
// input channel: push / full, one character per beat on char_in_i.
// output channel: empty / pop, one printed digit per beat on char_out_o,
//   with last_digit_o on the final digit and overflowed_o on that digit
//   when the value saturated.
// radix_mode_we_i writes radix_mode_i (0 decimal, 1 hex); write only when idle.
// a character enters a two-entry command queue; the back end folds each digit
// character into the accumulator, so digits stream at one beat per cycle while
// the back end is idle. a terminator in decimal runs a shift-add-3 conversion
// over the 32 value bits, then steps over 10 digit positions, leading zeros
// skipped; in hex it steps over the same 10 positions with no conversion.
// a decimal value prints up to ten digits, a hex value up to eight.
// a stalled receiver fills the two-entry result queue and halts printing;
// the command queue still takes up to two characters, then full rises.
// reset empties both queues, clears the accumulator and overflow mark and
// selects decimal.
// ============================================================================
`default_nettype none

`include "ascii_integer_parse_format_unit_macros.svh"

module ascii_integer_parse_format_unit
  import aipf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       radix_mode_we_i,
  input  wire logic       radix_mode_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_in_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      char_out_o,
  output logic            last_digit_o,
  output logic            overflowed_o
);

  logic radix_mode_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  res_t res_in;
  res_t res_out;
  logic res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_mode_q <= 1'b0;
    end else if (radix_mode_we_i) begin
      radix_mode_q <= radix_mode_i;
    end
  end

  aipf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hex_i       (radix_mode_q),
    .char_in_i   (char_in_i),
    .push_i      (push),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  aipf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  aipf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .res_o   (res_out),
    .pop_i   (pop)
  );

  assign char_out_o   = res_out.char_out;
  assign last_digit_o = res_out.last_digit;
  assign overflowed_o = res_out.overflowed;

  `AIPF_ASSERT_NEVER(a_push_into_full, res_push && res_full, "result beat pushed while full")
  `AIPF_ASSERT(a_pop_needs_cmd, cmd_pop |-> cmd_valid, "command popped from empty queue")
  `AIPF_ASSERT(a_ovf_on_last, (!empty && overflowed_o) |-> last_digit_o, "overflow off last digit")

endmodule

`default_nettype wire
